// ----- rtl/core/scts_pkg.sv -----
// ----------------------------------------------------------------------------
// scts_pkg
// Shared types, constants and controller/datapath signal groups for the
// sine, cosine and tangent series unit.
// ----------------------------------------------------------------------------
package scts_pkg;

  localparam int MAX_TERMS_DEF = 32;
  localparam int FRAC_BITS_DEF = 16;

  // Internal magnitudes carry 32 fraction bits.
  localparam int IFRAC = 32;
  localparam int TW    = 42;  // series term
  localparam int XW    = 40;  // reduced angle and its square
  localparam int AW    = 48;  // signed series sum
  localparam int VW    = 42;  // divisor and remainder
  localparam int HW    = TW / 2;

  localparam logic [35:0] TWO_PI_Q32   = 36'h6_487E_D511;
  localparam logic [33:0] SINE_LIMIT   = 34'h2_0000_0000;
  localparam logic [15:0] THRESH_RESET = 16'd1;
  localparam logic [31:0] RES_MAX      = 32'h7FFF_FFFF;
  localparam logic [31:0] RES_MIN      = 32'h8000_0000;

  localparam logic [1:0] OP_SIN  = 2'd0;
  localparam logic [1:0] OP_COS  = 2'd1;
  localparam logic [1:0] OP_TAN  = 2'd2;
  localparam logic [1:0] OP_NONE = 2'd3;

  typedef struct packed {
    logic [1:0]         operation;
    logic signed [31:0] angle;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] result;
    logic               overflow;
  } out_item_t;

  typedef enum logic [1:0] {
    OSEL_ZERO,
    OSEL_SERIES,
    OSEL_TAN,
    OSEL_TANZ
  } out_sel_t;

  typedef struct packed {
    logic     load;
    logic     red_start;
    logic     red_fix;
    logic     x2_start;
    logic     x2_take;
    logic     ser_init;
    logic     ser_cos;
    logic     ser_add;
    logic     term_mul_start;
    logic     term_div_start;
    logic     term_take;
    logic     save_sin;
    logic     tan_start;
    logic     out_load;
    out_sel_t out_sel;
  } cmd_t;

  typedef struct packed {
    logic [1:0] op;
    logic       red_done;
    logic       div_done;
    logic       mul_done;
    logic       term_small;
    logic       cos_zero;
  } status_t;

endpackage

// ----- rtl/core/scts_mul.sv -----
// ----------------------------------------------------------------------------
// scts_mul
// Two-pass multiplier: the first operand is taken in two halves and the
// product is kept with its low 32 bits dropped.
// ----------------------------------------------------------------------------
module scts_mul (
  input  logic                                    clk,
  input  logic                                    rst,
  input  logic                                    start,
  input  logic [scts_pkg::TW-1:0]                 a,
  input  logic [scts_pkg::XW-1:0]                 b,
  output logic                                    done,
  output logic [scts_pkg::TW+scts_pkg::XW-33:0]   prod_hi
);

  localparam int PW = scts_pkg::TW + scts_pkg::XW;
  localparam int LW = scts_pkg::HW + scts_pkg::XW;

  logic [scts_pkg::TW-1:0] a_r;
  logic [scts_pkg::XW-1:0] b_r;
  logic [LW-1:0]           lo;
  logic [PW-1:0]           prod;
  logic                    ph1;
  logic                    ph2;

  always_ff @(posedge clk) begin
    if (rst) begin
      ph1  <= 1'b0;
      ph2  <= 1'b0;
      done <= 1'b0;
    end else begin
      ph1  <= start;
      ph2  <= ph1;
      done <= ph2;
      if (start) begin
        a_r <= a;
        b_r <= b;
      end
      if (ph1) begin
        lo <= LW'(a_r[scts_pkg::HW-1:0] * b_r);
      end
      if (ph2) begin
        prod <= PW'(lo) +
                (PW'(a_r[scts_pkg::TW-1:scts_pkg::HW] * b_r) << scts_pkg::HW);
      end
    end
  end

  assign prod_hi = prod[PW-1:32];

endmodule

// ----- rtl/core/scts_div.sv -----
// ----------------------------------------------------------------------------
// scts_div
// Restoring divider, one quotient bit per cycle, giving the quotient.
// ----------------------------------------------------------------------------
module scts_div #(
  parameter int NW = 51
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    start,
  input  logic [NW-1:0]           dividend,
  input  logic [scts_pkg::VW-1:0] divisor,
  output logic                    done,
  output logic [NW-1:0]           quotient
);

  localparam int VW = scts_pkg::VW;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0] q;
  logic [VW-1:0] r;
  logic [VW-1:0] d;
  logic [CW-1:0] cnt;
  logic          busy;
  logic [VW:0]   r_sh;
  logic [VW:0]   diff;
  logic          ge;

  always_comb begin
    r_sh = {r, q[NW-1]};
    diff = r_sh - {1'b0, d};
    ge   = r_sh >= {1'b0, d};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        q    <= dividend;
        r    <= '0;
        d    <= divisor;
        cnt  <= CW'(NW);
        busy <= 1'b1;
      end else if (busy) begin
        q   <= {q[NW-2:0], ge};
        r   <= ge ? diff[VW-1:0] : r_sh[VW-1:0];
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign quotient = q;

endmodule

// ----- rtl/core/scts_ctrl.sv -----
// ----------------------------------------------------------------------------
// scts_ctrl
// Sequencer: angle reduction, the series loop, tangent quotient and the
// output register handshake.
// ----------------------------------------------------------------------------
module scts_ctrl #(
  parameter int MAX_TERMS = scts_pkg::MAX_TERMS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  input  scts_pkg::status_t st,
  output scts_pkg::cmd_t    cmd
);

  localparam int CNTW = $clog2(MAX_TERMS + 1);

  typedef enum logic [3:0] {
    S_IDLE, S_START, S_RED, S_X2S, S_X2W, S_SINIT,
    S_SCHK, S_SMUL, S_SDIV, S_TDIV, S_OUT
  } state_t;

  state_t             state, state_next;
  logic [CNTW-1:0]    cnt, cnt_next;
  logic               pass_cos, pass_cos_next;
  scts_pkg::out_sel_t sel, sel_next;
  logic               out_valid_next;
  logic               ser_done;
  logic               is_tan;

  assign ser_done = (cnt == CNTW'(MAX_TERMS)) || st.term_small;
  assign is_tan   = st.op == scts_pkg::OP_TAN;
  assign in_ready = state == S_IDLE;

  always_comb begin
    cmd            = '0;
    cmd.out_sel    = sel;
    state_next     = state;
    cnt_next       = cnt;
    pass_cos_next  = pass_cos;
    sel_next       = sel;
    out_valid_next = out_valid && !out_ready;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = S_START;
        end
      end
      S_START: begin
        pass_cos_next = 1'b0;
        if (st.op == scts_pkg::OP_NONE) begin
          sel_next   = scts_pkg::OSEL_ZERO;
          state_next = S_OUT;
        end else begin
          cmd.red_start = 1'b1;
          state_next    = S_RED;
        end
      end
      S_RED: begin
        if (st.red_done) begin
          cmd.red_fix = 1'b1;
          state_next  = S_X2S;
        end
      end
      S_X2S: begin
        cmd.x2_start = 1'b1;
        state_next   = S_X2W;
      end
      S_X2W: begin
        if (st.mul_done) begin
          cmd.x2_take = 1'b1;
          state_next  = S_SINIT;
        end
      end
      S_SINIT: begin
        cmd.ser_init = 1'b1;
        cmd.ser_cos  = pass_cos || (st.op == scts_pkg::OP_COS);
        cnt_next     = '0;
        state_next   = S_SCHK;
      end
      S_SCHK: begin
        if (ser_done) begin
          if (!is_tan) begin
            sel_next   = scts_pkg::OSEL_SERIES;
            state_next = S_OUT;
          end else if (!pass_cos) begin
            cmd.save_sin  = 1'b1;
            pass_cos_next = 1'b1;
            state_next    = S_SINIT;
          end else if (st.cos_zero) begin
            sel_next   = scts_pkg::OSEL_TANZ;
            state_next = S_OUT;
          end else begin
            cmd.tan_start = 1'b1;
            state_next    = S_TDIV;
          end
        end else begin
          cmd.ser_add        = 1'b1;
          cmd.term_mul_start = 1'b1;
          cnt_next           = cnt + CNTW'(1);
          state_next         = S_SMUL;
        end
      end
      S_SMUL: begin
        if (st.mul_done) begin
          cmd.term_div_start = 1'b1;
          state_next         = S_SDIV;
        end
      end
      S_SDIV: begin
        if (st.div_done) begin
          cmd.term_take = 1'b1;
          state_next    = S_SCHK;
        end
      end
      S_TDIV: begin
        if (st.div_done) begin
          sel_next   = scts_pkg::OSEL_TAN;
          state_next = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid || out_ready) begin
          cmd.out_load   = 1'b1;
          out_valid_next = 1'b1;
          state_next     = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      pass_cos  <= 1'b0;
      sel       <= scts_pkg::OSEL_ZERO;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      pass_cos  <= pass_cos_next;
      sel       <= sel_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

// ----- rtl/core/scts_dp.sv -----
// ----------------------------------------------------------------------------
// scts_dp
// Datapath: angle reduction, series term and sum registers, the shared
// multiplier and divider, rounding, saturation and the output register.
// ----------------------------------------------------------------------------
module scts_dp #(
  parameter int MAX_TERMS = scts_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = scts_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  scts_pkg::in_item_t  in_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata,
  input  scts_pkg::cmd_t      cmd,
  output scts_pkg::status_t   st,
  output scts_pkg::out_item_t out_data
);

  localparam int TW  = scts_pkg::TW;
  localparam int XW  = scts_pkg::XW;
  localparam int AW  = scts_pkg::AW;
  localparam int VW  = scts_pkg::VW;
  localparam int PHW = TW + XW - 32;
  localparam int SH  = scts_pkg::IFRAC - FRAC_BITS;
  localparam int RW  = 36 + SH;
  localparam int KW  = $clog2(SH + 1);
  localparam int DWB = 35 + FRAC_BITS;
  localparam int DW  = (DWB > PHW) ? DWB : PHW;
  localparam int DMX = 2 * MAX_TERMS + 2;
  localparam int DBW = $clog2(DMX + 1);
  localparam int DNW = $clog2(DMX * (DMX + 1) + 1);

  function automatic logic [AW-1:0] mag_of(input logic signed [AW-1:0] v);
    return v[AW-1] ? AW'(-v) : AW'(v);
  endfunction

  function automatic logic [32:0] pack(input logic neg, input logic [DW-1:0] m);
    logic [31:0] lo;
    lo = m[31:0];
    if (!neg && m > DW'(33'h0_7FFF_FFFF)) begin
      return {1'b1, scts_pkg::RES_MAX};
    end else if (neg && m > DW'(33'h0_8000_0000)) begin
      return {1'b1, scts_pkg::RES_MIN};
    end else begin
      return {1'b0, neg ? (32'd0 - lo) : lo};
    end
  endfunction

  scts_pkg::in_item_t     in_r;
  logic [15:0]            thr;
  logic [XW-1:0]          xr;
  logic [XW-1:0]          x2;
  logic [TW-1:0]          term;
  logic signed [AW-1:0]   acc;
  logic signed [AW-1:0]   s_save;
  logic                   neg_r;
  logic [DBW-1:0]         d;
  logic [DNW-1:0]         den;
  scts_pkg::out_item_t    out_r;
  logic [RW-1:0]          red_r;
  logic [KW-1:0]          red_k;
  logic                   red_busy;
  logic                   red_done;

  logic [31:0]            abs_a;
  logic [RW-1:0]          absx;
  logic [RW-1:0]          red_sub;
  logic [TW-1:0]          limit;
  logic [AW-1:0]          c_mag;
  logic [AW-1:0]          s_mag;
  logic [AW-1:0]          s_clip;
  logic [DW-1:0]          tan_num;
  logic [AW:0]            rnd;
  logic [32:0]            pk_series;
  logic [32:0]            pk_tan;

  logic                   mul_start;
  logic [TW-1:0]          mul_a;
  logic [XW-1:0]          mul_b;
  logic                   mul_done;
  logic [PHW-1:0]         prod_hi;
  logic                   div_start;
  logic [DW-1:0]          div_n;
  logic [VW-1:0]          div_d;
  logic                   div_done;
  logic [DW-1:0]          div_q;

  always_comb begin
    abs_a   = in_r.angle[31] ? 32'(-in_r.angle) : 32'(in_r.angle);
    absx    = RW'(abs_a) << SH;
    red_sub = RW'(scts_pkg::TWO_PI_Q32) << red_k;
    limit   = TW'(thr) << SH;
    c_mag   = mag_of(acc);
    s_mag   = mag_of(s_save);
    s_clip  = (s_mag > AW'(scts_pkg::SINE_LIMIT)) ? AW'(scts_pkg::SINE_LIMIT) : s_mag;
    tan_num = (DW'(s_clip) << FRAC_BITS) + DW'(c_mag >> 1);
    rnd     = (AW + 1)'(c_mag) + ((AW + 1)'(1) << (SH - 1));
    pk_series = pack(acc[AW-1], DW'(rnd >> SH));
    pk_tan    = pack(s_save[AW-1] != acc[AW-1], div_q);
  end

  assign mul_start = cmd.x2_start || cmd.term_mul_start;
  assign mul_a     = cmd.x2_start ? TW'(xr) : term;
  assign mul_b     = cmd.x2_start ? xr : x2;

  always_comb begin
    div_start = cmd.term_div_start || cmd.tan_start;
    priority if (cmd.term_div_start) begin
      div_n = DW'(prod_hi);
      div_d = VW'(den);
    end else begin
      div_n = tan_num;
      div_d = VW'(c_mag);
    end
  end

  scts_mul u_mul (
    .clk     (clk),
    .rst     (rst),
    .start   (mul_start),
    .a       (mul_a),
    .b       (mul_b),
    .done    (mul_done),
    .prod_hi (prod_hi)
  );

  scts_div #(.NW(DW)) u_div (
    .clk       (clk),
    .rst       (rst),
    .start     (div_start),
    .dividend  (div_n),
    .divisor   (div_d),
    .done      (div_done),
    .quotient  (div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= scts_pkg::THRESH_RESET;
    end else if (cfg_we) begin
      thr <= cfg_wdata;
    end
  end

  // Angle reduction subtracts 2pi wherever it fits, shifted down one place per cycle.
  always_ff @(posedge clk) begin
    if (rst) begin
      red_busy <= 1'b0;
      red_done <= 1'b0;
    end else begin
      red_done <= 1'b0;
      if (cmd.red_start) begin
        red_busy <= 1'b1;
      end else if (red_busy && (red_k == '0)) begin
        red_busy <= 1'b0;
        red_done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.red_start) begin
      red_r <= absx;
      red_k <= KW'(SH);
    end else if (red_busy) begin
      if (red_r >= red_sub) begin
        red_r <= red_r - red_sub;
      end
      red_k <= red_k - KW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= in_data;
    end
    if (cmd.red_fix) begin
      xr <= (in_r.angle[31] && (red_r != '0)) ?
            XW'(RW'(scts_pkg::TWO_PI_Q32) - red_r) : XW'(red_r);
    end
    if (cmd.x2_take) begin
      x2 <= XW'(prod_hi);
    end
    if (cmd.ser_init) begin
      acc   <= '0;
      neg_r <= 1'b0;
      term  <= cmd.ser_cos ? (TW'(1) << scts_pkg::IFRAC) : TW'(xr);
      d     <= cmd.ser_cos ? DBW'(1) : DBW'(2);
      den   <= cmd.ser_cos ? DNW'(2) : DNW'(6);
    end else if (cmd.ser_add) begin
      acc   <= neg_r ? acc - AW'(term) : acc + AW'(term);
      neg_r <= !neg_r;
    end else if (cmd.term_take) begin
      term <= TW'(div_q);
      d    <= d + DBW'(2);
      den  <= den + (DNW'(d) << 2) + DNW'(6);
    end
    if (cmd.save_sin) begin
      s_save <= acc;
    end
    if (cmd.out_load) begin
      unique case (cmd.out_sel)
        scts_pkg::OSEL_ZERO: begin
          out_r.result   <= '0;
          out_r.overflow <= 1'b0;
        end
        scts_pkg::OSEL_SERIES: begin
          out_r.result   <= pk_series[31:0];
          out_r.overflow <= pk_series[32];
        end
        scts_pkg::OSEL_TAN: begin
          out_r.result   <= pk_tan[31:0];
          out_r.overflow <= pk_tan[32];
        end
        scts_pkg::OSEL_TANZ: begin
          out_r.result   <= s_save[AW-1] ? scts_pkg::RES_MIN : scts_pkg::RES_MAX;
          out_r.overflow <= 1'b1;
        end
        default: begin
          out_r.result   <= '0;
          out_r.overflow <= 1'b0;
        end
      endcase
    end
  end

  assign st.op         = in_r.operation;
  assign st.red_done   = red_done;
  assign st.div_done   = div_done;
  assign st.mul_done   = mul_done;
  assign st.term_small = term < limit;
  assign st.cos_zero   = acc == '0;
  assign out_data      = out_r;

endmodule

// ----- rtl/core/sin_cos_tan_series_unit.sv -----
// Sine or cosine runs the angle reduction, squares the reduced angle and then
// sums N series terms, each a multiply and a divide. Tangent adds a cosine pass
// and, unless the cosine sum is zero, a quotient divide; code 3 returns zero.
// Throughput: one item at a time; the next item is taken in the cycle after the result
// is loaded, and a stalled output holds the sequencer until it drains.
// Reset (synchronous, active high) idles the sequencer and sets the threshold to 1.
// ----------------------------------------------------------------------------
// sin_cos_tan_series_unit
// Sine, cosine and tangent of a fixed-point angle by Maclaurin series.
// ----------------------------------------------------------------------------
module sin_cos_tan_series_unit #(
  parameter int MAX_TERMS = scts_pkg::MAX_TERMS_DEF,
  parameter int FRAC_BITS = scts_pkg::FRAC_BITS_DEF
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_ready,
  input  scts_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_ready,
  output scts_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [15:0]         cfg_wdata
);

  scts_pkg::cmd_t    cmd;
  scts_pkg::status_t st;

  scts_ctrl #(.MAX_TERMS(MAX_TERMS)) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .st        (st),
    .cmd       (cmd)
  );

  scts_dp #(.MAX_TERMS(MAX_TERMS), .FRAC_BITS(FRAC_BITS)) u_dp (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .cmd       (cmd),
    .st        (st),
    .out_data  (out_data)
  );

`ifndef SYNTHESIS
  a_one_item: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready)
    else $error("second item taken while one is in work");

  a_sat_value: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_data.overflow |->
      out_data.result == 32'sh7FFF_FFFF || out_data.result == 32'sh8000_0000)
    else $error("overflow set without a saturated result");

  a_units_busy: assert property (@(posedge clk) disable iff (rst)
    st.mul_done || st.div_done |-> !in_ready)
    else $error("arithmetic unit finished while the sequencer was idle");
`endif

endmodule

// ----- tb/sin_cos_tan_series_unit_tb.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sin_cos_tan_series_unit_tb
// Drives angles and operation codes into the series unit through random
// bursts and stalls, predicts each sine, cosine or tangent result with a
// bit-exact fixed-point model, and compares every returned item with it.
// ----------------------------------------------------------------------------
module sin_cos_tan_series_unit_tb;

  localparam logic [63:0] TWO_PI = 64'd26986075409;
  localparam int          N_TERMS = scts_pkg::MAX_TERMS_DEF;
  localparam int          FBITS = scts_pkg::FRAC_BITS_DEF;
  localparam longint      CYCLE_LIMIT = 64'd40000000;

  logic                clk = 1'b0;
  logic                rst = 1'b1;
  logic                in_valid = 1'b0;
  logic                in_ready;
  scts_pkg::in_item_t  in_data = '0;
  logic                out_valid;
  logic                out_ready = 1'b0;
  scts_pkg::out_item_t out_data;
  logic                cfg_we = 1'b0;
  logic [15:0]         cfg_wdata = '0;

  logic [15:0]         thresh_model;
  scts_pkg::out_item_t pending_results[$];
  int                  fail_count = 0;
  int                  items_sent = 0;
  int                  results_seen = 0;
  longint              cycle_count = 0;
  int                  stall_phase = 0;

  sin_cos_tan_series_unit u_dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
    .out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_wdata(cfg_wdata)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("sin_cos_tan_series_unit verification failed");
      $finish;
    end
  end

  function automatic logic [63:0] mul_q32(logic [63:0] a, logic [63:0] b);
    logic [127:0] p;
    p = a * b;
    return p[95:32];
  endfunction

  function automatic logic signed [63:0] series_sum(logic [63:0] x, bit cosine);
    logic [63:0] x2, term, d, limit;
    logic signed [63:0] acc;
    bit neg;
    x2 = mul_q32(x, x);
    term = cosine ? 64'h1_0000_0000 : x;
    d = cosine ? 64'd1 : 64'd2;
    limit = {48'd0, thresh_model} << (32 - FBITS);
    acc = 0;
    neg = 1'b0;
    for (int n = 0; n < N_TERMS && term >= limit; n++) begin
      acc = neg ? acc - $signed(term) : acc + $signed(term);
      neg = !neg;
      term = mul_q32(term, x2) / (d * (d + 64'd1));
      d = d + 64'd2;
    end
    return acc;
  endfunction

  function automatic scts_pkg::out_item_t saturate(bit neg, logic [63:0] mag);
    scts_pkg::out_item_t r;
    r.overflow = 1'b0;
    if (!neg && mag > 64'h7FFF_FFFF) begin
      r.result = scts_pkg::RES_MAX;
      r.overflow = 1'b1;
    end else if (neg && mag > 64'h8000_0000) begin
      r.result = scts_pkg::RES_MIN;
      r.overflow = 1'b1;
    end else begin
      r.result = neg ? 32'(-mag) : mag[31:0];
    end
    return r;
  endfunction

  function automatic scts_pkg::out_item_t trig_predict(scts_pkg::in_item_t it);
    logic signed [63:0] x, s, c;
    logic [63:0] sm, cm, m;
    scts_pkg::out_item_t r;
    x = 64'(signed'(it.angle)) <<< (32 - FBITS);
    x = x % $signed(TWO_PI);
    if (x < 0) x = x + $signed(TWO_PI);
    if (it.operation == scts_pkg::OP_NONE) begin
      r = '0;
    end else if (it.operation != scts_pkg::OP_TAN) begin
      s = series_sum(x, it.operation == scts_pkg::OP_COS);
      m = s < 0 ? -s : s;
      r = saturate(s < 0, (m + (64'd1 << (31 - FBITS))) >> (32 - FBITS));
    end else begin
      s = series_sum(x, 1'b0);
      c = series_sum(x, 1'b1);
      if (c == 0) begin
        r.result = s >= 0 ? scts_pkg::RES_MAX : scts_pkg::RES_MIN;
        r.overflow = 1'b1;
      end else begin
        sm = s < 0 ? -s : s;
        if (sm > 64'(scts_pkg::SINE_LIMIT)) sm = 64'(scts_pkg::SINE_LIMIT);
        cm = c < 0 ? -c : c;
        r = saturate((s < 0) != (c < 0), ((sm << FBITS) + cm / 2) / cm);
      end
    end
    return r;
  endfunction

  // In each repeating window the receiver is always ready at first, then stalls at random.
  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      stall_phase <= stall_phase + 1;
      if (stall_phase % 512 < 128) out_ready <= 1'b1;
      else out_ready <= ((stall_phase % 7) != 3) && ($urandom_range(0, 3) != 0);
    end
  end

  always @(posedge clk) begin
    scts_pkg::out_item_t exp_item;
    if (!rst && out_valid && out_ready) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        $display("%0t: unexpected result %h/%0b", $time, out_data.result,
                 out_data.overflow);
        fail_count++;
      end else begin
        exp_item = pending_results.pop_front();
        if (out_data.result !== exp_item.result) begin
          $display("%0t: result expected %h actual %h", $time, exp_item.result,
                   out_data.result);
          fail_count++;
        end
        if (out_data.overflow !== exp_item.overflow) begin
          $display("%0t: overflow expected %0b actual %0b", $time,
                   exp_item.overflow, out_data.overflow);
          fail_count++;
        end
      end
    end
  end

  // Valid stays high after acceptance only when another item follows at once.
  task automatic send_item(logic [1:0] op, logic [31:0] ang);
    scts_pkg::in_item_t it;
    it.operation = op;
    it.angle = ang;
    in_valid <= 1'b1;
    in_data <= it;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_results.push_back(trig_predict(it));
    items_sent++;
  endtask

  task automatic idle_cycles(int count);
    in_valid <= 1'b0;
    repeat (count) @(posedge clk);
  endtask

  task automatic drain_results();
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (60) @(posedge clk);
  endtask

  task automatic write_threshold(logic [15:0] value);
    drain_results();
    repeat (400) @(posedge clk);
    cfg_we <= 1'b1;
    cfg_wdata <= value;
    thresh_model = value;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  function automatic logic [31:0] random_angle();
    case ($urandom_range(0, 5))
      0: return $urandom();
      1: return $urandom_range(0, 32'h0006_487F);
      2: return -$urandom_range(0, 32'h0006_487F);
      3: return 32'h0001_921F + $urandom_range(0, 8) - 4;
      4: return 32'h0004_B65F + $urandom_range(0, 8) - 4;
      default: return $urandom_range(0, 32'h0003_0000);
    endcase
  endfunction

  task automatic send_burst(int count, bit any_op);
    int left;
    left = count;
    while (left > 0) begin
      for (int k = $urandom_range(1, 12); k > 0 && left > 0; k--, left--)
        send_item(any_op ? 2'($urandom_range(0, 3)) : 2'($urandom_range(0, 2)),
                  random_angle());
      if ($urandom_range(0, 2) != 0) idle_cycles($urandom_range(1, 90));
    end
  endtask

  task automatic test_directed_extremes();
    logic [31:0] angles[8] = '{32'h0, 32'h7FFF_FFFF, 32'h8000_0000, 32'hFFFF_FFFF,
                                32'h0001_921F, 32'h0003_243F, 32'h0004_B65F,
                                32'h0006_487E};
    foreach (angles[i]) begin
      send_item(scts_pkg::OP_SIN, angles[i]);
      send_item(scts_pkg::OP_COS, angles[i]);
      send_item(scts_pkg::OP_TAN, angles[i]);
    end
    send_item(scts_pkg::OP_NONE, 32'h1234_5678);
  endtask

  task automatic test_random_default();
    send_burst(500, 1'b1);
    drain_results();
  endtask

  task automatic test_threshold_sweep();
    logic [15:0] levels[4] = '{16'd0, 16'hFFFF, 16'd37, 16'd1};
    foreach (levels[i]) begin
      write_threshold(levels[i]);
      send_burst(200, i == 3);
    end
    write_threshold(16'($urandom_range(0, 16'hFFFF)));
    send_burst(50, 1'b1);
  endtask

  initial begin
    thresh_model = scts_pkg::THRESH_RESET;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_directed_extremes();
    test_random_default();
    test_threshold_sweep();
    drain_results();
    $display("Sent %0d items and checked %0d results over thresholds 0, 1, 37,",
             items_sent, results_seen);
    $display("65535 and a random level, with all four operation codes.");
    if (fail_count == 0) begin
      $display("sin_cos_tan_series_unit verification clean");
    end else begin
      $display("sin_cos_tan_series_unit verification failed");
    end
    $finish;
  end
endmodule
